[design/hmac_sha256_expiring_token_engine_macros.svh]
// Assertion macros for the token engine.
`ifndef HMAC_SHA256_EXPIRING_TOKEN_ENGINE_MACROS_SVH
`define HMAC_SHA256_EXPIRING_TOKEN_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[design/hste_pkg.sv]
// Shared types, constants and functions for the token engine.
package hste_pkg;
  localparam int KeyWords = 4;
  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_TAG = 2'd1,
    STATUS_EXPIRED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FINAL, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [511:0] block;
    logic [255:0] hin;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic [255:0] hout;
  } cmp_rsp_t;

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] kround(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

[design/hste_compress.sv]
// SHA-256 compression: one round per cycle over a 16-word schedule window.
module hste_compress import hste_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [255:0] hsave;
  logic [5:0] rnd;
  logic busy, fin;
  logic [31:0] t1, t2, s0, s1, wnew;

  always_comb begin
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + kround(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      rnd <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int i = 0; i < 16; i++) w[i] <= req.block[511 - 32*i -: 32];
      {a, b, c, d, e, f, g, h} <= req.hin;
      hsave <= req.hin;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  assign rsp.done = fin;
  assign rsp.hout = {hsave[255:224] + a, hsave[223:192] + b, hsave[191:160] + c,
                     hsave[159:128] + d, hsave[127:96] + e, hsave[95:64] + f,
                     hsave[63:32] + g, hsave[31:0] + h};
endmodule

[design/hmac_sha256_expiring_token_engine.sv]
// Top level of the expiring-token engine: key registers, sequencer, result.
// Usage:
//   Raise start with a request while busy is low; the word is taken at that
//   edge. Fields: req_type (0 mint, 1 verify), expiry_time, nonce, presented
//   tag and current_time.
//   busy stays high while the four SHA-256 compressions run on one shared
//   round unit. Each pass goes through ST_LOAD, ST_ROUND (the rounds, then the
//   compression result) and ST_FINAL; after the fourth pass ST_DONE gives the
//   done strobe.
//   done is high for one cycle with tag_high, tag_low and status; the
//   receiver cannot stall, so the result is shown once and dropped.
//   One request at a time: start is taken only while busy is low. Key words
//   are written via cfg_we/cfg_index/cfg_data; the user does so only while
//   idle; the block does not enforce it. Synchronous reset zeroes the keys and
//   returns to idle. status: 0 ok or minted, 1 tag mismatch (wins), 2 expired.
module hmac_sha256_expiring_token_engine import hste_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] expiry_time,
  input  logic [63:0] nonce_high,
  input  logic [63:0] nonce_low,
  input  logic [63:0] presented_tag_high,
  input  logic [63:0] presented_tag_low,
  input  logic [63:0] current_time,
  output logic        done,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low,
  output logic [1:0]  status
);
`include "hmac_sha256_expiring_token_engine_macros.svh"

  logic [63:0] key [KeyWords];
  state_t state, state_next;
  logic [1:0] pass;
  logic [255:0] hcur, inner;
  logic rq;
  logic [63:0] exp_r, nh, nl, pth, ptl, now_r;
  cmp_req_t creq;
  cmp_rsp_t crsp;
  logic [511:0] kblk, blk;
  logic [255:0] hsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyWords; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    kblk = {key[0], key[1], key[2], key[3], 256'd0};
    unique case (pass)
      2'd0: begin
        blk = kblk ^ {64{IpadByte}};
        hsel = HInit;
      end
      2'd1: begin
        blk = {exp_r, nh, nl, 8'h80, 248'd0, 64'd704};
        hsel = hcur;
      end
      2'd2: begin
        blk = kblk ^ {64{OpadByte}};
        hsel = HInit;
      end
      default: begin
        blk = {inner, 8'h80, 184'd0, 64'd768};
        hsel = hcur;
      end
    endcase
    creq.block = blk;
    creq.hin = hsel;
    creq.start = (state == ST_LOAD);
  end

  hste_compress u_cmp (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (crsp.done) state_next = ST_FINAL;
      ST_FINAL: state_next = (pass == 2'd3) ? ST_DONE : ST_LOAD;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= '0;
    end else if (state == ST_IDLE) begin
      pass <= '0;
    end else if (state == ST_FINAL) begin
      pass <= pass + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      rq <= req_type; exp_r <= expiry_time; nh <= nonce_high; nl <= nonce_low;
      pth <= presented_tag_high; ptl <= presented_tag_low; now_r <= current_time;
    end
    if (crsp.done) begin
      hcur <= crsp.hout;
      if (pass == 2'd1) inner <= crsp.hout;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign tag_high = hcur[255:192];
  assign tag_low = hcur[191:128];

  always_comb begin
    if (!rq) status = STATUS_OK;
    else if (((tag_high ^ pth) | (tag_low ^ ptl)) != 64'd0) status = STATUS_BAD_TAG;
    else if (now_r >= exp_r) status = STATUS_EXPIRED;
    else status = STATUS_OK;
  end

  `ASSERT_IMPL(a_done_once, clk, rst, done |=> !done)
  `ASSERT_IMPL(a_done_after_busy, clk, rst, done |-> $past(busy))
  `ASSERT_NEVER(a_load_not_idle, clk, rst, creq.start && !busy)
  `ASSERT_IMPL(a_start_takes, clk, rst, (start && !busy) |=> busy)
endmodule
